>>> rtl/vns_pkg.sv
// Shared types and constants for the nearest-seed classifier.
`timescale 1ns / 1ps

package vns_pkg;

  localparam int COORD_W  = 10;
  localparam int CHAN_W   = 8;
  localparam int SQ_W     = 2 * COORD_W;
  localparam int DIST_W   = SQ_W + 1;
  localparam int CELLS_W  = 9;
  localparam int INDEX_W  = 8;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_PIXEL = 1'b1;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [DIST_W-1:0]  dist_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } colour_t;

  typedef struct packed {
    coord_t  x;
    coord_t  y;
    colour_t colour;
  } seed_entry_t;

  // Marks travelling with each seed through the scan pipeline.
  typedef struct packed {
    logic first;
    logic last;
  } scan_tag_t;

endpackage

>>> rtl/vns_seed_mem.sv
// Seed table: one write port for loads, one registered read port for the scan.
`timescale 1ns / 1ps

module vns_seed_mem #(
  parameter int DEPTH = 256,
  parameter int ADDR_W = 8
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [ADDR_W-1:0]   wr_addr,
  input  vns_pkg::seed_entry_t wr_data,
  input  logic                rd_en,
  input  logic [ADDR_W-1:0]   rd_addr,
  output vns_pkg::seed_entry_t rd_data
);

  vns_pkg::seed_entry_t mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/vns_dist_unit.sv
// Two-stage squared-distance unit with a side tag that keeps step with the data.
`timescale 1ns / 1ps

module vns_dist_unit #(
  parameter int TAG_W = 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_vld,
  input  vns_pkg::coord_t      seed_x,
  input  vns_pkg::coord_t      seed_y,
  input  vns_pkg::coord_t      pix_x,
  input  vns_pkg::coord_t      pix_y,
  input  logic [TAG_W-1:0]     tag_in,
  output logic                 out_vld,
  output vns_pkg::dist_t       dist_sq,
  output logic [TAG_W-1:0]     tag_out
);

  vns_pkg::coord_t    dx;
  vns_pkg::coord_t    dy;
  logic               vld1;
  logic [TAG_W-1:0]   tag1;
  logic [vns_pkg::SQ_W-1:0] sq_x;
  logic [vns_pkg::SQ_W-1:0] sq_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1    <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      vld1    <= in_vld;
      out_vld <= vld1;
    end
  end

  always_ff @(posedge clk) begin
    dx   <= (seed_x > pix_x) ? (seed_x - pix_x) : (pix_x - seed_x);
    dy   <= (seed_y > pix_y) ? (seed_y - pix_y) : (pix_y - seed_y);
    tag1 <= tag_in;
  end

  assign sq_x = vns_pkg::SQ_W'(dx * dx);
  assign sq_y = vns_pkg::SQ_W'(dy * dy);

  always_ff @(posedge clk) begin
    dist_sq <= vns_pkg::DIST_W'(sq_x) + vns_pkg::DIST_W'(sq_y);
    tag_out <= tag1;
  end

endmodule

>>> rtl/vns_best_track.sv
// Running minimum over the scan: keeps the nearest seed seen so far.
`timescale 1ns / 1ps

module vns_best_track #(
  parameter int IDX_W = 8
) (
  input  logic              clk,
  input  logic              upd_vld,
  input  logic              first,
  input  vns_pkg::dist_t    dist_sq,
  input  logic [IDX_W-1:0]  idx,
  input  vns_pkg::colour_t  colour,
  output vns_pkg::dist_t    best_dist,
  output logic [IDX_W-1:0]  best_idx,
  output vns_pkg::colour_t  best_colour
);

  // Strict compare, so the lowest index holds on a tie.
  always_ff @(posedge clk) begin
    if (upd_vld && (first || (dist_sq < best_dist))) begin
      best_dist   <= dist_sq;
      best_idx    <= idx;
      best_colour <= colour;
    end
  end

endmodule

>>> rtl/voronoi_nearest_seed.sv
// Nearest-seed classifier: a pixel request scans the loaded seeds one per cycle through a
// shared distance unit and returns the colour, index and squared distance of the nearest
// seed (lowest index on a tie). A load request writes one seed and leaves the block idle,
// ready for the next request. A pixel request occupies the block (num_cells clamped to
// MAX_CELLS) while it reads each seed from the seed table in turn, then through the read,
// the two distance stages and the result hand-over. A pixel with num_cells of zero gives
// no result. The result sits in an output register, so the next request is taken while
// it waits to be collected.
`timescale 1ns / 1ps

module voronoi_nearest_seed #(
  parameter int MAX_CELLS = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [8:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        req_type,
  input  logic [7:0]  seed_index,
  input  logic [9:0]  seed_x,
  input  logic [9:0]  seed_y,
  input  logic [7:0]  seed_red,
  input  logic [7:0]  seed_green,
  input  logic [7:0]  seed_blue,
  input  logic [9:0]  pixel_x,
  input  logic [9:0]  pixel_y,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [7:0]  nearest_index,
  output logic [20:0] nearest_dist_sq
);

  localparam int IDX_W   = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int SCTAG_W = $bits(vns_pkg::scan_tag_t);
  localparam int COL_W   = $bits(vns_pkg::colour_t);
  localparam int TAG_W   = SCTAG_W + IDX_W + COL_W;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0]               state;
  logic [vns_pkg::CELLS_W-1:0] num_cells;
  vns_pkg::coord_t          pix_x;
  vns_pkg::coord_t          pix_y;
  logic [IDX_W-1:0]         last_idx;
  logic [IDX_W-1:0]         cnt;

  logic                     in_acc;
  logic [31:0]              seed_index_ext;
  logic [31:0]              cells_ext;
  logic [31:0]              eff_cells;
  logic [31:0]              eff_last;
  logic                     load_wr;
  vns_pkg::seed_entry_t     wr_entry;
  vns_pkg::seed_entry_t     rd_entry;
  logic                     scan_rd;

  logic                     v1;
  vns_pkg::scan_tag_t       tag1;
  logic [IDX_W-1:0]         idx1;

  logic [TAG_W-1:0]         du_tag_in;
  logic [TAG_W-1:0]         du_tag_out;
  logic                     v3;
  vns_pkg::dist_t           dist3;
  vns_pkg::scan_tag_t       tag3;
  logic [IDX_W-1:0]         idx3;
  vns_pkg::colour_t         colour3;

  vns_pkg::dist_t           best_dist;
  logic [IDX_W-1:0]         best_idx;
  vns_pkg::colour_t         best_colour;
  logic [31:0]              best_idx_ext;
  logic                     out_load;

  assign in_ready = (state == ST_IDLE);
  assign in_acc   = in_valid && in_ready;

  assign seed_index_ext = 32'(seed_index);
  assign cells_ext      = 32'(num_cells);
  assign eff_cells      = (cells_ext > 32'(MAX_CELLS)) ? 32'(MAX_CELLS) : cells_ext;
  assign eff_last       = eff_cells - 32'd1;

  // Loads aimed beyond the table are dropped.
  assign load_wr = in_acc && (req_type == vns_pkg::REQ_LOAD) &&
                   (seed_index_ext < 32'(MAX_CELLS));

  assign wr_entry.x             = seed_x;
  assign wr_entry.y             = seed_y;
  assign wr_entry.colour.red    = seed_red;
  assign wr_entry.colour.green  = seed_green;
  assign wr_entry.colour.blue   = seed_blue;

  assign scan_rd = (state == ST_SCAN);

  always_ff @(posedge clk) begin
    if (rst) begin
      num_cells <= '0;
    end else if (cfg_write) begin
      num_cells <= cfg_data;
    end
  end

  vns_seed_mem #(
    .DEPTH  (MAX_CELLS),
    .ADDR_W (IDX_W)
  ) u_seed_mem (
    .clk     (clk),
    .wr_en   (load_wr),
    .wr_addr (seed_index_ext[IDX_W-1:0]),
    .wr_data (wr_entry),
    .rd_en   (scan_rd),
    .rd_addr (cnt),
    .rd_data (rd_entry)
  );

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_acc && (req_type == vns_pkg::REQ_PIXEL) && (eff_cells != 32'd0)) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (cnt == last_idx) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (v3 && tag3.last) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      pix_x    <= pixel_x;
      pix_y    <= pixel_y;
      last_idx <= eff_last[IDX_W-1:0];
      cnt      <= '0;
    end else if (scan_rd) begin
      cnt <= cnt + 1'b1;
    end
  end

  // The read data appears in the cycle after the address; its marks follow alongside.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= scan_rd;
    end
  end

  always_ff @(posedge clk) begin
    tag1.first <= (cnt == '0);
    tag1.last  <= (cnt == last_idx);
    idx1       <= cnt;
  end

  assign du_tag_in = {tag1, idx1, rd_entry.colour};

  vns_dist_unit #(
    .TAG_W (TAG_W)
  ) u_dist (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (v1),
    .seed_x  (rd_entry.x),
    .seed_y  (rd_entry.y),
    .pix_x   (pix_x),
    .pix_y   (pix_y),
    .tag_in  (du_tag_in),
    .out_vld (v3),
    .dist_sq (dist3),
    .tag_out (du_tag_out)
  );

  assign tag3    = du_tag_out[TAG_W-1 -: SCTAG_W];
  assign idx3    = du_tag_out[COL_W +: IDX_W];
  assign colour3 = du_tag_out[COL_W-1:0];

  vns_best_track #(
    .IDX_W (IDX_W)
  ) u_best (
    .clk         (clk),
    .upd_vld     (v3),
    .first       (tag3.first),
    .dist_sq     (dist3),
    .idx         (idx3),
    .colour      (colour3),
    .best_dist   (best_dist),
    .best_idx    (best_idx),
    .best_colour (best_colour)
  );

  // Hand the result over once the previous one has been collected.
  assign out_load     = (state == ST_FINISH) && (!out_valid || out_ready);
  assign best_idx_ext = 32'(best_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_red         <= best_colour.red;
      out_green       <= best_colour.green;
      out_blue        <= best_colour.blue;
      nearest_index   <= best_idx_ext[vns_pkg::INDEX_W-1:0];
      nearest_dist_sq <= best_dist;
    end
  end

endmodule
